>>> design/ipl4_pkg.sv
package ipl4_pkg;

   localparam int unsigned MAX_PACKET_BYTES = 65535;
   localparam int unsigned POS_W = 16;

   localparam logic [3:0] VERSION_V4 = 4'd4;
   localparam logic [3:0] VERSION_V6 = 4'd6;
   localparam logic [3:0] IHL_MIN = 4'd5;
   localparam logic [5:0] V6_HDR_BYTES = 6'd40;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic [1:0] IP_KIND_NONE = 2'd0;
   localparam logic [1:0] IP_KIND_V4 = 2'd1;
   localparam logic [1:0] IP_KIND_V6 = 2'd2;

   localparam logic [1:0] L4_KIND_NONE = 2'd0;
   localparam logic [1:0] L4_KIND_TCP = 2'd1;
   localparam logic [1:0] L4_KIND_UDP = 2'd2;

   localparam logic [POS_W-1:0] TCP_MIN_BYTES = 16'd20;
   localparam logic [POS_W-1:0] UDP_MIN_BYTES = 16'd8;
   localparam logic [6:0] TCP_CHECK_OFS = 7'd16;
   localparam logic [6:0] UDP_CHECK_OFS = 7'd6;

   // per-packet running state, also the snapshot handed to the finish stage
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [15:0]      hdr_sum;
      logic [15:0]      l4_sum;
      logic [15:0]      pseudo_sum;
      logic [7:0]       hold;
      logic [3:0]       version;
      logic [3:0]       hdr_words;
      logic [7:0]       protocol;
   } snap_type;

   typedef struct packed {
      logic [1:0]  ip_kind;
      logic        ip_check_valid;
      logic [15:0] ip_check;
      logic [1:0]  l4_kind;
      logic [15:0] l4_check;
      logic [6:0]  l4_check_offset;
   } rsp_type;

   // one's-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

endpackage

>>> design/ipl4_ifs.sv
interface ipl4_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ipl4_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  ip_kind;
   logic        ip_check_valid;
   logic [15:0] ip_check;
   logic [1:0]  l4_kind;
   logic [15:0] l4_check;
   logic [6:0]  l4_check_offset;

   modport source (output valid, ip_kind, ip_check_valid, ip_check, l4_kind, l4_check,
                   l4_check_offset, input ready);
   modport sink (input valid, ip_kind, ip_check_valid, ip_check, l4_kind, l4_check,
                 l4_check_offset, output ready);
endinterface

>>> design/ip_l4_checksum_offload_unit.sv
// After a packet's last byte is taken, its result passes the packet state snapshot
// register, then the result register. Throughput: one byte per cycle unless stalled;
// each byte pair takes one 16-bit end-around-carry add per sum it feeds.
// A result can wait in the output register while the next packet's bytes keep flowing.
// Reset: synchronous, active high; clears the running sums and all pipeline valids.
module ip_l4_checksum_offload_unit (
   input logic         clock,
   input logic         reset,
   ipl4_req_if.sink    req_bus,
   ipl4_rsp_if.source  rsp_bus
);
   import ipl4_pkg::*;

   snap_type         snap;
   snap_type         fin_ff;
   logic             fin_valid_ff;
   logic             fin_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             out_free;
   logic             fin_free;
   logic             take;

   logic             v4;
   logic             v6;
   logic [5:0]       h;
   logic [POS_W-1:0] hdr_len;
   logic [POS_W-1:0] tlen;
   logic             hdr_ok;
   logic [15:0]      pad;
   logic [18:0]      sum5;
   logic [16:0]      fold1;
   logic [15:0]      fold2;
   logic [15:0]      l4c;
   logic             is_tcp;
   logic             is_udp;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign fin_free      = !fin_valid_ff || out_free;
   assign req_bus.ready = fin_free;
   assign take          = req_bus.valid && fin_free;

   ipl4_byte_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_bus.data_byte),
      .last_byte (req_bus.last_byte),
      .snap      (snap)
   );

   // finish: one multi-operand one's-complement sum over the packet snapshot
   always_comb begin
      v4      = (fin_ff.version == VERSION_V4) && (fin_ff.hdr_words >= IHL_MIN);
      v6      = (fin_ff.version == VERSION_V6);
      h       = v4 ? {fin_ff.hdr_words, 2'b00} : V6_HDR_BYTES;
      hdr_len = {{(POS_W-6){1'b0}}, h};
      hdr_ok  = (v4 || v6) && (fin_ff.pos >= hdr_len);
      tlen    = fin_ff.pos - hdr_len;
      pad     = fin_ff.pos[0] ? {fin_ff.hold, 8'h00} : 16'h0000;
      sum5    = {3'b000, fin_ff.pseudo_sum} + {3'b000, fin_ff.l4_sum} + {3'b000, pad}
              + {11'b0, fin_ff.protocol} + {3'b000, tlen};
      fold1   = {1'b0, sum5[15:0]} + {14'b0, sum5[18:16]};
      fold2   = fold1[15:0] + {15'b0, fold1[16]};
      l4c     = ~fold2;
      is_tcp  = (fin_ff.protocol == PROTO_TCP) && (tlen >= TCP_MIN_BYTES);
      is_udp  = (fin_ff.protocol == PROTO_UDP) && (tlen >= UDP_MIN_BYTES);

      rsp_in = '0;
      if (hdr_ok) begin
         rsp_in.ip_kind = v4 ? IP_KIND_V4 : IP_KIND_V6;
         if (v4) begin
            rsp_in.ip_check_valid = 1'b1;
            rsp_in.ip_check       = ~fin_ff.hdr_sum;
         end
         if (is_tcp) begin
            rsp_in.l4_kind         = L4_KIND_TCP;
            rsp_in.l4_check        = l4c;
            rsp_in.l4_check_offset = {1'b0, h} + TCP_CHECK_OFS;
         end else if (is_udp) begin
            rsp_in.l4_kind         = L4_KIND_UDP;
            rsp_in.l4_check        = (l4c == 16'h0000) ? 16'hFFFF : l4c;
            rsp_in.l4_check_offset = {1'b0, h} + UDP_CHECK_OFS;
         end
      end

      if (take && req_bus.last_byte)
         fin_valid_in = 1'b1;
      else if (out_free)
         fin_valid_in = 1'b0;
      else
         fin_valid_in = fin_valid_ff;

      if (out_free)
         rsp_valid_in = fin_valid_ff;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_bus.last_byte)
         fin_ff <= snap;
      if (out_free && fin_valid_ff)
         rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.ip_kind         = rsp_ff.ip_kind;
   assign rsp_bus.ip_check_valid  = rsp_ff.ip_check_valid;
   assign rsp_bus.ip_check        = rsp_ff.ip_check;
   assign rsp_bus.l4_kind         = rsp_ff.l4_kind;
   assign rsp_bus.l4_check        = rsp_ff.l4_check;
   assign rsp_bus.l4_check_offset = rsp_ff.l4_check_offset;

endmodule

>>> design/ipl4_byte_acc.sv
module ipl4_byte_acc (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output ipl4_pkg::snap_type snap
);
   import ipl4_pkg::*;

   snap_type         acc_ff;
   snap_type         acc_in;
   snap_type         upd;
   logic [POS_W-1:0] p;
   logic [POS_W-1:0] hdr_len;
   logic [POS_W-1:0] t;
   logic             in_range;
   logic [3:0]       ver;
   logic [3:0]       hw;
   logic             v4;
   logic             v6;
   logic [5:0]       h;
   logic [7:0]       proto;
   logic             past_hdr;
   logic [7:0]       mb;
   logic [15:0]      w;

   always_comb begin
      p        = acc_ff.pos;
      in_range = p < POS_W'(MAX_PACKET_BYTES);
      ver      = (p == '0) ? data_byte[7:4] : acc_ff.version;
      hw       = (p == '0) ? data_byte[3:0] : acc_ff.hdr_words;
      v4       = (ver == VERSION_V4) && (hw >= IHL_MIN);
      v6       = (ver == VERSION_V6);
      h        = v4 ? {hw, 2'b00} : V6_HDR_BYTES;
      hdr_len  = {{(POS_W-6){1'b0}}, h};
      proto    = ((v4 && p == 16'd9) || (v6 && p == 16'd6)) ? data_byte : acc_ff.protocol;
      past_hdr = p >= hdr_len;
      t        = p - hdr_len;

      // checksum fields are summed as zero
      mb = data_byte;
      if (v4 && (p == 16'd10 || p == 16'd11))
         mb = 8'h00;
      if (past_hdr && proto == PROTO_TCP && (t == 16'd16 || t == 16'd17))
         mb = 8'h00;
      if (past_hdr && proto == PROTO_UDP && (t == 16'd6 || t == 16'd7))
         mb = 8'h00;
      w = {acc_ff.hold, mb};

      upd = acc_ff;
      if (in_range) begin
         upd.pos       = p + 1'b1;
         upd.version   = ver;
         upd.hdr_words = hw;
         if (v4 || v6) begin
            upd.protocol = proto;
            if (!p[0]) begin
               upd.hold = mb;
            end else begin
               if ((v4 && p >= 16'd12 && p < 16'd20) || (v6 && p >= 16'd8 && p < 16'd40))
                  upd.pseudo_sum = oc_add(acc_ff.pseudo_sum, w);
               if (v4 && !past_hdr)
                  upd.hdr_sum = oc_add(acc_ff.hdr_sum, w);
               if (past_hdr)
                  upd.l4_sum = oc_add(acc_ff.l4_sum, w);
            end
         end
      end

      if (take && last_byte)
         acc_in = '0;
      else if (take)
         acc_in = upd;
      else
         acc_in = acc_ff;
   end

   assign snap = upd;

   always_ff @(posedge clock) begin
      if (reset)
         acc_ff <= '0;
      else
         acc_ff <= acc_in;
   end

endmodule

>>> design/ipl4_checker.sv
module ipl4_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  ip_kind,
   input logic        ip_check_valid,
   input logic [15:0] ip_check,
   input logic [1:0]  l4_kind,
   input logic [15:0] l4_check,
   input logic [6:0]  l4_check_offset
);
   import ipl4_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ip_kind) && $stable(ip_check)
         && $stable(ip_check_valid) && $stable(l4_kind) && $stable(l4_check)
         && $stable(l4_check_offset))
      else $error("rsp changed while stalled");

   // a fresh result requires an earlier last-byte transfer
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("rsp without matching last-byte transfer");

   // header checksum only on IPv4; nothing checked means nothing reported
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ip_check_valid == (ip_kind == IP_KIND_V4))
         && (ip_kind != IP_KIND_NONE || (l4_kind == L4_KIND_NONE && ip_check == 16'h0000)))
      else $error("ip kind inconsistent with result fields");

   a_l4_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (l4_kind == L4_KIND_NONE && l4_check == 16'h0000
                     && l4_check_offset == 7'd0)
         || (l4_kind == L4_KIND_UDP && l4_check != 16'h0000)
         || (l4_kind == L4_KIND_TCP))
      else $error("transport fields inconsistent");

endmodule

bind ip_l4_checksum_offload_unit ipl4_checker u_ipl4_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_last        (req_bus.last_byte),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .ip_kind         (rsp_bus.ip_kind),
   .ip_check_valid  (rsp_bus.ip_check_valid),
   .ip_check        (rsp_bus.ip_check),
   .l4_kind         (rsp_bus.l4_kind),
   .l4_check        (rsp_bus.l4_check),
   .l4_check_offset (rsp_bus.l4_check_offset)
);

>>> sim/ipl4_checksum_checker.sv
`timescale 1ns / 100ps

module ipl4_checksum_checker (
   input  logic        clock,
   input  logic        reset,
   ipl4_req_if         req_bus,
   ipl4_rsp_if         rsp_bus,
   output int unsigned fail_count,
   output int unsigned pending
);
   import ipl4_pkg::*;

   // running packet state, mirrors what the block accumulates per byte
   logic [15:0] pos_cnt;
   logic [15:0] hdr_acc;
   logic [15:0] l4_acc;
   logic [15:0] addr_acc;
   logic [7:0]  hi_byte;
   logic [3:0]  ver;
   logic [3:0]  ihl;
   logic [7:0]  proto;

   rsp_type     pending_checksums[$];
   int unsigned mismatch_total = 0;
   int unsigned results_seen = 0;

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] t;
      t = {16'b0, a} + {16'b0, b};
      t = {16'b0, t[15:0]} + {16'b0, t[31:16]};
      return t[15:0];
   endfunction

   function automatic logic ipv4_ok();
      return ver == VERSION_V4 && ihl >= IHL_MIN;
   endfunction

   function automatic logic ipv6_ok();
      return ver == VERSION_V6;
   endfunction

   function automatic logic [15:0] ip_hdr_bytes();
      return ipv4_ok() ? {10'b0, ihl, 2'b00} : 16'(V6_HDR_BYTES);
   endfunction

   task automatic wipe_state();
      pos_cnt  = '0;
      hdr_acc  = '0;
      l4_acc   = '0;
      addr_acc = '0;
      hi_byte  = '0;
      ver      = '0;
      ihl      = '0;
      proto    = '0;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      logic [15:0] p;
      logic [15:0] h;
      logic [15:0] t;
      logic [15:0] w;
      logic [7:0]  mb;
      logic        v4;
      logic        v6;
      p = pos_cnt;
      if (p == 0) begin
         ver = b[7:4];
         ihl = b[3:0];
      end
      v4 = ipv4_ok();
      v6 = ipv6_ok();
      if (!v4 && !v6) return;
      h = ip_hdr_bytes();
      if ((v4 && p == 9) || (v6 && p == 6)) proto = b;
      // checksum fields are summed as zero
      mb = b;
      if (v4 && (p == 10 || p == 11)) mb = 8'h00;
      if (p >= h) begin
         t = p - h;
         if (proto == PROTO_TCP && (t == 16 || t == 17)) mb = 8'h00;
         if (proto == PROTO_UDP && (t == 6 || t == 7)) mb = 8'h00;
      end
      if (!p[0]) begin
         hi_byte = mb;
         return;
      end
      w = {hi_byte, mb};
      if ((v4 && p >= 12 && p < 20) || (v6 && p >= 8 && p < 40))
         addr_acc = fold_add(addr_acc, w);
      if (v4 && p < h) hdr_acc = fold_add(hdr_acc, w);
      if (p >= h) l4_acc = fold_add(l4_acc, w);
   endtask

   task automatic close_packet(output rsp_type r);
      logic [15:0] len;
      logic [15:0] h;
      logic [15:0] tlen;
      logic [15:0] s;
      logic        v4;
      logic        v6;
      r = '0;
      len = pos_cnt;
      v4 = ipv4_ok();
      v6 = ipv6_ok();
      h = ip_hdr_bytes();
      if ((v4 || v6) && len >= h) begin
         tlen = len - h;
         // odd length: last byte padded with a zero low byte
         if (len[0]) l4_acc = fold_add(l4_acc, {hi_byte, 8'h00});
         r.ip_kind = v4 ? IP_KIND_V4 : IP_KIND_V6;
         if (v4) begin
            r.ip_check_valid = 1'b1;
            r.ip_check = ~hdr_acc;
         end
         if ((proto == PROTO_TCP && tlen >= TCP_MIN_BYTES) ||
             (proto == PROTO_UDP && tlen >= UDP_MIN_BYTES)) begin
            s = fold_add(addr_acc, l4_acc);
            s = fold_add(s, {8'h00, proto});
            s = fold_add(s, tlen);
            r.l4_check = ~s;
            if (proto == PROTO_TCP) begin
               r.l4_kind = L4_KIND_TCP;
               r.l4_check_offset = h[6:0] + TCP_CHECK_OFS;
            end else begin
               r.l4_kind = L4_KIND_UDP;
               r.l4_check_offset = h[6:0] + UDP_CHECK_OFS;
               if (r.l4_check == 16'h0000) r.l4_check = 16'hFFFF;
            end
         end
      end
      wipe_state();
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want_v);
      mismatch_total++;
      $display("%0t: checksum mismatch, result %0d, %s: got %h want %h",
               $time, results_seen, what, got, want_v);
   endtask

   task automatic check_field(input string what, input logic [15:0] got,
                              input logic [15:0] want_v);
      if (got !== want_v) report_mismatch(what, got, want_v);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wipe_state();
         pending_checksums.delete();
      end else begin
         // results first: a result never belongs to a packet closing at this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pending_checksums.size() == 0) begin
               report_mismatch("result with no packet pending", rsp_bus.l4_check, 16'h0000);
            end else begin
               want = pending_checksums.pop_front();
               check_field("ip_kind", 16'(rsp_bus.ip_kind), 16'(want.ip_kind));
               check_field("ip_check_valid", 16'(rsp_bus.ip_check_valid),
                           16'(want.ip_check_valid));
               check_field("ip_check", rsp_bus.ip_check, want.ip_check);
               check_field("l4_kind", 16'(rsp_bus.l4_kind), 16'(want.l4_kind));
               check_field("l4_check", rsp_bus.l4_check, want.l4_check);
               check_field("l4_check_offset", 16'(rsp_bus.l4_check_offset),
                           16'(want.l4_check_offset));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            // bytes past the saturation count are dropped
            if (pos_cnt < MAX_PACKET_BYTES) begin
               absorb_byte(req_bus.data_byte);
               pos_cnt++;
            end
            if (req_bus.last_byte) begin
               close_packet(want);
               pending_checksums.push_back(want);
            end
         end
      end
      pending <= pending_checksums.size();
      fail_count <= mismatch_total;
   end

endmodule

>>> sim/ip_l4_checksum_offload_unit_tb.sv
`timescale 1ns / 100ps

module ip_l4_checksum_offload_unit_tb;
   import ipl4_pkg::*;

   localparam int unsigned STALL_LIMIT     = 5000;
   localparam int unsigned PRESSURE_CYCLES = 400;
   localparam int unsigned RANDOM_BYTES    = 770;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned bytes_sent = 0;
   logic [7:0]  pkt[$];
   bit          squeeze_go = 1'b0;
   bit          squeeze_on = 1'b0;

   ipl4_req_if req_bus();
   ipl4_rsp_if rsp_bus();

   ip_l4_checksum_offload_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ipl4_checksum_checker checksum_watch (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(12, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic logic [7:0] odd_proto();
      logic [7:0] p;
      do p = 8'($urandom); while (p == PROTO_TCP || p == PROTO_UDP);
      return p;
   endfunction

   function automatic logic [7:0] pick_proto();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 4) return PROTO_TCP;
      if (r < 8) return PROTO_UDP;
      return odd_proto();
   endfunction

   // header below IHL 5 still gets 20 bytes so the packet looks plausible
   task automatic make_v4(input logic [3:0] ihl, input logic [7:0] proto,
                          input int unsigned l4_len);
      int unsigned hlen;
      hlen = (ihl < IHL_MIN) ? 20 : ihl * 4;
      pkt.delete();
      pkt.push_back({VERSION_V4, ihl});
      for (int i = 1; i < hlen; i++) pkt.push_back(i == 9 ? proto : 8'($urandom));
      for (int i = 0; i < l4_len; i++) pkt.push_back(8'($urandom));
   endtask

   task automatic make_v6(input logic [7:0] proto, input int unsigned l4_len);
      pkt.delete();
      pkt.push_back({VERSION_V6, 4'($urandom)});
      for (int i = 1; i < V6_HDR_BYTES; i++) pkt.push_back(i == 6 ? proto : 8'($urandom));
      for (int i = 0; i < l4_len; i++) pkt.push_back(8'($urandom));
   endtask

   task automatic make_other(input int unsigned len);
      logic [3:0] v;
      do v = 4'($urandom); while (v == VERSION_V4 || v == VERSION_V6);
      pkt.delete();
      pkt.push_back({v, 4'($urandom)});
      for (int i = 1; i < len; i++) pkt.push_back(8'($urandom));
   endtask

   task automatic trim_to(input int unsigned n);
      while (pkt.size() > n) void'(pkt.pop_back());
   endtask

   task automatic send_packet(input bit eager);
      int unsigned gap;
      bit          no_gaps;
      no_gaps = eager || ($urandom_range(3) == 0);
      for (int i = 0; i < pkt.size(); i++) begin
         gap = no_gaps ? 0 : pick_gap();
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.data_byte <= pkt[i];
         req_bus.last_byte <= (i == pkt.size() - 1);
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         bytes_sent++;
      end
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned stretch;
      int unsigned run;
      forever begin
         if (squeeze_go && !squeeze_on) begin
            squeeze_on = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         stretch = ($urandom_range(3) == 0) ? $urandom_range(200, 50) : $urandom_range(30, 1);
         for (int k = 0; k < stretch; k++) begin
            if (squeeze_go && !squeeze_on) break;
            @(posedge clock);
         end
         run = pick_gap();
         if (run != 0 && !(squeeze_go && !squeeze_on)) begin
            rsp_bus.ready <= 1'b0;
            repeat (run) @(posedge clock);
         end
      end
   end

   // no transfer on either side for too long ends the run
   initial begin
      int unsigned idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle = 0;
         else
            idle++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int unsigned start;
      int unsigned r;
      logic [31:0] acc;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // boundary lengths for TCP and UDP, plus short, bad-IHL, other-protocol and other-version packets
      make_v4(IHL_MIN, PROTO_TCP, 20);          send_packet(0);
      make_v4(IHL_MIN, PROTO_TCP, 19);          send_packet(0);
      make_v4(IHL_MIN, PROTO_UDP, 8);           send_packet(0);
      make_v4(IHL_MIN, PROTO_UDP, 7);           send_packet(0);
      make_v4(4'd15, PROTO_TCP, 33);            send_packet(0);
      make_v4(IHL_MIN, PROTO_UDP, 9);           send_packet(0);
      make_v4(IHL_MIN, odd_proto(), 10);        send_packet(0);
      make_v4(IHL_MIN, PROTO_TCP, 0);           send_packet(0);
      make_v4(IHL_MIN, PROTO_TCP, 0); trim_to(13); send_packet(0);
      make_v4(4'd4, PROTO_TCP, 20);             send_packet(0);
      make_v4(4'd0, PROTO_UDP, 8);              send_packet(0);
      make_v4(IHL_MIN, PROTO_TCP, 0); trim_to(1);  send_packet(0);
      make_v6(PROTO_TCP, 20);                   send_packet(0);
      make_v6(PROTO_UDP, 8);                    send_packet(0);
      make_v6(PROTO_UDP, 7);                    send_packet(0);
      make_v6(PROTO_TCP, 21);                   send_packet(0);
      make_v6(odd_proto(), 10);                 send_packet(0);
      make_v6(PROTO_UDP, 0); trim_to(39);       send_packet(0);
      make_v6(PROTO_TCP, 0); trim_to(1);        send_packet(0);
      make_other(24);                           send_packet(0);
      make_other(1);                            send_packet(0);

      // all-ones and all-zero content
      make_v4(IHL_MIN, PROTO_TCP, 20);
      for (int i = 1; i < pkt.size(); i++) if (i != 9) pkt[i] = 8'hFF;
      send_packet(0);
      make_v6(PROTO_UDP, 8);
      for (int i = 1; i < pkt.size(); i++) if (i != 6) pkt[i] = 8'h00;
      send_packet(0);

      // UDP whose sum comes out zero: last word patched so the sum folds to all ones
      make_v4(IHL_MIN, PROTO_UDP, 12);
      pkt[30] = 8'h00;
      pkt[31] = 8'h00;
      acc = '0;
      for (int i = 12; i < 32; i += 2) if (i != 26) acc += {16'b0, pkt[i], pkt[i + 1]};
      acc += 32'(PROTO_UDP) + 32'd12;
      acc = {16'b0, acc[15:0]} + {16'b0, acc[31:16]};
      acc = {16'b0, acc[15:0]} + {16'b0, acc[31:16]};
      pkt[30] = ~acc[15:8];
      pkt[31] = ~acc[7:0];
      send_packet(0);

      // result side holds off while short packets go back to back
      req_bus.valid <= 1'b0;
      squeeze_go = 1'b1;
      wait (squeeze_on);
      @(posedge clock);
      for (int n = 0; n < 10; n++) begin
         make_v4(IHL_MIN, $urandom_range(1) ? PROTO_TCP : PROTO_UDP, $urandom_range(8));
         send_packet(1);
      end

      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         r = $urandom_range(99);
         if (r < 50) begin
            make_v4(r < 10 ? 4'($urandom_range(15, 6)) : IHL_MIN, pick_proto(),
                    $urandom_range(40));
         end else if (r < 75) begin
            make_v6(pick_proto(), $urandom_range(40));
         end else if (r < 85) begin
            if (r < 80) make_v4(4'($urandom_range(15, 5)), pick_proto(), 0);
            else make_v6(pick_proto(), 0);
            trim_to($urandom_range(pkt.size() - 1, 1));
         end else if (r < 92) begin
            make_other($urandom_range(30, 1));
         end else begin
            make_v4(4'($urandom_range(4)), pick_proto(), $urandom_range(20));
         end
         send_packet(0);
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
